// ===== rtl/ame_pkg.sv =====
package ame_pkg;

  localparam int unsigned MemWordsDef = 4096;
  localparam int unsigned WordBitsDef = 16;
  localparam int unsigned ModeW       = 4;
  localparam int unsigned AddrW       = 12;
  localparam int unsigned FieldW      = 16;

  typedef enum logic [ModeW-1:0] {
    MODE_LOAD   = 4'd0,
    MODE_STORE  = 4'd1,
    MODE_ADD    = 4'd2,
    MODE_SUBT   = 4'd3,
    MODE_INPUT  = 4'd4,
    MODE_OUTPUT = 4'd5,
    MODE_HALT   = 4'd6,
    MODE_SKIP   = 4'd7,
    MODE_JUMP   = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    SKIP_NEG   = 2'd0,
    SKIP_ZERO  = 2'd1,
    SKIP_POS   = 2'd2,
    SKIP_NEVER = 2'd3
  } skip_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ===== rtl/ame_mem.sv =====
module ame_mem #(
  parameter int unsigned Depth = ame_pkg::MemWordsDef,
  parameter int unsigned Width = ame_pkg::WordBitsDef,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/accumulator_machine_execute_unit.sv =====
// Execute stage of an accumulator machine.
// Input channel (in_valid_i/in_ready_o): one decoded instruction per beat,
// mode_i, operand_address_i and keyboard_value_i.
// Output channel (out_valid_o/out_ready_i): one result beat per instruction,
// carrying the accumulator, program counter, display value and halt status
// after that instruction.
// The word memory read is registered: the operand word is read when the
// instruction is accepted, and the instruction executes and commits in ST_EXEC
// once the output register is free; a new instruction is taken only after that.
// Reset: accumulator, program counter and halt flag clear at once; then a
// clearing pass writes zero to every memory word, one per cycle, over all
// MEM_WORDS words (4096 by default) with in_ready_o low.
// Stall: a finished result waits in the output register; the next
// instruction is still accepted, but it cannot commit until that result is
// taken, and in_ready_o stays low meanwhile.
// Once a halt executes, later instructions are accepted and report the held
// state with output_valid_o low and halted_o high.
module accumulator_machine_execute_unit
  import ame_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MemWordsDef,
  parameter int unsigned WORD_BITS = WordBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ModeW-1:0]         mode_i,
  input  logic [AddrW-1:0]         operand_address_i,
  input  logic signed [FieldW-1:0] keyboard_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [FieldW-1:0] accumulator_value_o,
  output logic [AddrW-1:0]         program_counter_o,
  output logic                     output_valid_o,
  output logic signed [FieldW-1:0] output_value_o,
  output logic                     halted_o
);

  localparam int unsigned IdxW = $clog2(MEM_WORDS);
  localparam int unsigned XW   = (WORD_BITS > FieldW) ? WORD_BITS : FieldW;

  state_e state_q, state_d;

  logic                 in_acc;
  logic                 mem_clear;
  logic                 exec_go;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] mem_rdata;

  logic [IdxW-1:0]      clr_idx_q, clr_idx_d;
  logic                 clr_last;

  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [AddrW-1:0]     pc_q, pc_d;
  logic                 halt_q, halt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 ov_q, ov_d;

  mode_e                mode_q;
  logic [AddrW-1:0]     addr_q;
  logic signed [FieldW-1:0] kb_q;

  // Address folding: addr mod MEM_WORDS from two constant tables
  logic [IdxW-1:0]      lo_mod [256];
  logic [IdxW-1:0]      hi_mod [16];
  logic [IdxW:0]        idx_sum;
  logic [IdxW-1:0]      mem_idx;

  for (genvar g = 0; g < 256; g++) begin : g_lo_tab
    assign lo_mod[g] = IdxW'(g % MEM_WORDS);
  end

  for (genvar g = 0; g < 16; g++) begin : g_hi_tab
    assign hi_mod[g] = IdxW'((g * 256) % MEM_WORDS);
  end

  assign idx_sum = {1'b0, lo_mod[operand_address_i[7:0]]}
                 + {1'b0, hi_mod[operand_address_i[11:8]]};

  always_comb begin
    if (idx_sum >= (IdxW + 1)'(MEM_WORDS)) begin
      mem_idx = IdxW'(idx_sum - (IdxW + 1)'(MEM_WORDS));
    end else begin
      mem_idx = idx_sum[IdxW-1:0];
    end
  end

  // Control
  assign clr_last = (clr_idx_q == IdxW'(MEM_WORDS - 1));
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_clear  = 1'b0;
    exec_go    = 1'b0;
    case (state_q)
      ST_CLEAR: mem_clear  = 1'b1;
      ST_IDLE:  in_ready_o = 1'b1;
      ST_EXEC:  exec_go    = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign clr_idx_d = mem_clear ? clr_idx_q + IdxW'(1) : clr_idx_q;

  // Memory access: clear sweep, or store on accept
  assign mem_we    = mem_clear
                  || (in_acc && (mode_e'(mode_i) == MODE_STORE) && !halt_q);
  assign mem_waddr = mem_clear ? clr_idx_q : mem_idx;
  assign mem_wdata = mem_clear ? '0 : acc_q;

  ame_mem #(
    .Depth(MEM_WORDS),
    .Width(WORD_BITS)
  ) u_mem (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (in_acc),
    .raddr_i(mem_idx),
    .rdata_o(mem_rdata)
  );

  // Execute
  logic [XW-1:0] kb_x;
  logic          acc_neg;
  logic          acc_zero;
  logic          skip;

  assign kb_x     = XW'(kb_q);
  assign acc_neg  = acc_q[WORD_BITS-1];
  assign acc_zero = (acc_q == '0);

  always_comb begin
    case (skip_e'(addr_q[11:10]))
      SKIP_NEG:  skip = acc_neg;
      SKIP_ZERO: skip = acc_zero;
      SKIP_POS:  skip = !acc_neg && !acc_zero;
      default:   skip = 1'b0;
    endcase
  end

  always_comb begin
    acc_d  = acc_q;
    pc_d   = pc_q;
    halt_d = halt_q;
    ov_d   = ov_q;
    if (exec_go) begin
      ov_d = 1'b0;
      if (!halt_q) begin
        case (mode_q)
          MODE_LOAD:   acc_d  = mem_rdata;
          MODE_ADD:    acc_d  = acc_q + mem_rdata;
          MODE_SUBT:   acc_d  = acc_q - mem_rdata;
          MODE_INPUT:  acc_d  = kb_x[WORD_BITS-1:0];
          MODE_OUTPUT: ov_d   = 1'b1;
          MODE_HALT:   halt_d = 1'b1;
          MODE_SKIP: begin
            if (skip) pc_d = pc_q + AddrW'(1);
          end
          MODE_JUMP:   pc_d   = addr_q;
          default:     acc_d  = acc_q;
        endcase
      end
    end
  end

  assign out_valid_d = exec_go || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      acc_q       <= '0;
      pc_q        <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      acc_q       <= acc_d;
      pc_q        <= pc_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_e'(mode_i);
      addr_q <= operand_address_i;
      kb_q   <= keyboard_value_i;
    end
  end

  // Result
  logic [XW-1:0] acc_x;

  assign acc_x               = XW'($signed(acc_q));
  assign out_valid_o         = out_valid_q;
  assign accumulator_value_o = acc_x[FieldW-1:0];
  assign program_counter_o   = pc_q;
  assign output_valid_o      = ov_q;
  assign output_value_o      = ov_q ? acc_x[FieldW-1:0] : '0;
  assign halted_o            = halt_q;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("instruction accepted during memory clear");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (!in_ready_o && state_q == ST_EXEC))
    else $error("second instruction accepted before commit");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  a_no_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !mem_we)
    else $error("memory write while instruction executes");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(acc_q) && $stable(pc_q) && $stable(ov_q)))
    else $error("result state changed while output stalled");
`endif

endmodule

// ===== dv/accumulator_machine_execute_unit_tb.sv =====
module accumulator_machine_execute_unit_tb
  import ame_pkg::*;
;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 10;

  typedef struct {
    logic [FieldW-1:0] acc;
    logic [AddrW-1:0]  pc;
    logic              disp_valid;
    logic [FieldW-1:0] disp_value;
    logic              halted;
  } exec_result_t;

  class exec_scoreboard;
    logic [FieldW-1:0] acc;
    logic [AddrW-1:0]  pc;
    logic [FieldW-1:0] word_mem [MemWordsDef];
    logic              halted;
    exec_result_t      pending_results [$];
    int                errors;
    int                checked;

    function new();
      acc     = '0;
      pc      = '0;
      halted  = 1'b0;
      errors  = 0;
      checked = 0;
      foreach (word_mem[i]) word_mem[i] = '0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, checked, msg);
      errors++;
    endtask

    function void predict_instr(logic [ModeW-1:0] mode, logic [AddrW-1:0] addr,
                                logic [FieldW-1:0] kb);
      exec_result_t r;
      skip_e        cond;
      logic         take;
      logic         disp;
      disp = 1'b0;
      take = 1'b0;
      if (!halted) begin
        case (mode)
          MODE_LOAD:   acc = word_mem[addr];
          MODE_STORE:  word_mem[addr] = acc;
          MODE_ADD:    acc = acc + word_mem[addr];
          MODE_SUBT:   acc = acc - word_mem[addr];
          MODE_INPUT:  acc = kb;
          MODE_OUTPUT: disp = 1'b1;
          MODE_HALT:   halted = 1'b1;
          MODE_SKIP: begin
            cond = skip_e'(addr[AddrW-1:AddrW-2]);
            case (cond)
              SKIP_NEG:  take = acc[FieldW-1];
              SKIP_ZERO: take = (acc == '0);
              SKIP_POS:  take = !acc[FieldW-1] && (acc != '0);
              default:   take = 1'b0;
            endcase
            if (take) pc = pc + 1'b1;
          end
          MODE_JUMP:   pc = addr;
          default: ;
        endcase
      end
      r.acc        = acc;
      r.pc         = pc;
      r.disp_valid = disp;
      r.disp_value = disp ? acc : '0;
      r.halted     = halted;
      pending_results.push_back(r);
    endfunction

    task compare_field(string name, logic [FieldW-1:0] got, logic [FieldW-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        compare_field("accumulator", got.acc, want.acc);
        compare_field("program counter", FieldW'(got.pc), FieldW'(want.pc));
        compare_field("display valid", FieldW'(got.disp_valid), FieldW'(want.disp_valid));
        compare_field("display value", got.disp_value, want.disp_value);
        compare_field("halted", FieldW'(got.halted), FieldW'(want.halted));
      end
      checked++;
    endtask
  endclass

  logic                     clk_i             = 1'b0;
  logic                     rst_ni            = 1'b0;
  logic                     in_valid_i        = 1'b0;
  logic                     in_ready_o;
  logic [ModeW-1:0]         mode_i            = '0;
  logic [AddrW-1:0]         operand_address_i = '0;
  logic signed [FieldW-1:0] keyboard_value_i  = '0;
  logic                     out_valid_o;
  logic                     out_ready_i       = 1'b0;
  logic signed [FieldW-1:0] accumulator_value_o;
  logic [AddrW-1:0]         program_counter_o;
  logic                     output_valid_o;
  logic signed [FieldW-1:0] output_value_o;
  logic                     halted_o;

  exec_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    stall_pct     = 0;
  logic           hold_req      = 1'b0;
  int unsigned    cycles        = 0;

  accumulator_machine_execute_unit u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .mode_i,
    .operand_address_i,
    .keyboard_value_i,
    .out_valid_o,
    .out_ready_i,
    .accumulator_value_o,
    .program_counter_o,
    .output_valid_o,
    .output_value_o,
    .halted_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    exec_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.acc        = accumulator_value_o;
      got.pc         = program_counter_o;
      got.disp_valid = output_valid_o;
      got.disp_value = output_value_o;
      got.halted     = halted_o;
      sb.check_result(got);
    end
  end

  task automatic send_instr(logic [ModeW-1:0] mode, logic [AddrW-1:0] addr,
                            logic [FieldW-1:0] kb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    mode_i            <= mode;
    operand_address_i <= addr;
    keyboard_value_i  <= kb;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_instr(mode, addr, kb);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random();
    int unsigned       roll;
    logic [ModeW-1:0]  m;
    logic [AddrW-1:0]  a;
    logic [FieldW-1:0] k;
    roll = $urandom_range(99);
    a = ($urandom_range(3) == 0) ? AddrW'($urandom) : AddrW'($urandom_range(15));
    k = FieldW'($urandom);
    if ($urandom_range(9) == 0) k = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    if (roll < 15)      m = MODE_LOAD;
    else if (roll < 33) m = MODE_STORE;
    else if (roll < 47) m = MODE_ADD;
    else if (roll < 59) m = MODE_SUBT;
    else if (roll < 73) m = MODE_INPUT;
    else if (roll < 81) m = MODE_OUTPUT;
    else if (roll < 90) m = MODE_SKIP;
    else if (roll < 95) m = MODE_JUMP;
    else                m = ModeW'($urandom_range(9, 15));
    if (m == MODE_SKIP || m == MODE_JUMP) a = AddrW'($urandom);
    send_instr(m, a, k);
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned count,
                           logic long_hold);
    send_idle_pct = idle;
    stall_pct     = stall;
    if (long_hold) hold_req = 1'b1;
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_instr(MODE_INPUT,  12'h000, 16'h7fff);
    send_instr(MODE_STORE,  12'h000, 16'h0000);
    send_instr(MODE_INPUT,  12'h000, 16'h8000);
    send_instr(MODE_STORE,  12'hfff, 16'hffff);
    send_instr(MODE_ADD,    12'h000, 16'h0000);
    send_instr(MODE_SUBT,   12'hfff, 16'h0000);
    send_instr(MODE_OUTPUT, 12'h000, 16'h0000);
    send_instr(MODE_SKIP,   12'h000, 16'h0000);
    send_instr(MODE_INPUT,  12'h000, 16'hffff);
    send_instr(MODE_SKIP,   12'h3ff, 16'h0000);
    send_instr(MODE_SKIP,   12'h400, 16'h0000);
    send_instr(MODE_LOAD,   12'h123, 16'h0000);
    send_instr(MODE_SKIP,   12'h7ff, 16'h0000);
    send_instr(MODE_SKIP,   12'h800, 16'h0000);
    send_instr(MODE_INPUT,  12'h000, 16'h0001);
    send_instr(MODE_SKIP,   12'hbff, 16'h0000);
    send_instr(MODE_SKIP,   12'hc00, 16'h0000);
    send_instr(MODE_SKIP,   12'hfff, 16'h0000);
    send_instr(MODE_JUMP,   12'hfff, 16'h0000);
    send_instr(MODE_SKIP,   12'h800, 16'h0000);
    send_instr(MODE_JUMP,   12'h555, 16'h0000);
    send_instr(MODE_OUTPUT, 12'h000, 16'h0000);
    send_instr(4'd9,        12'h000, 16'h0000);
    send_instr(4'd15,       12'hfff, 16'hffff);
    send_instr(MODE_LOAD,   12'hfff, 16'h0000);
    drain();

    run_phase(0,  0,  220, 1'b1);
    run_phase(71, 0,  210, 1'b0);
    run_phase(0,  71, 210, 1'b0);
    run_phase(26, 26, 210, 1'b0);

    send_idle_pct = 26;
    stall_pct     = 26;
    send_instr(MODE_HALT,   12'h000, 16'h0000);
    send_instr(MODE_INPUT,  12'h000, 16'h1234);
    send_instr(MODE_STORE,  12'h000, 16'h0000);
    send_instr(MODE_OUTPUT, 12'h000, 16'h0000);
    send_instr(MODE_JUMP,   12'h0aa, 16'h0000);
    send_instr(MODE_SKIP,   12'hc00, 16'h0000);
    send_instr(MODE_HALT,   12'hfff, 16'h0000);
    drain();
    repeat (DrainWait) @(negedge clk_i);

    if (sb.pending_results.size() != 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ame_pkg.sv
rtl/ame_mem.sv
rtl/accumulator_machine_execute_unit.sv
dv/accumulator_machine_execute_unit_tb.sv
